// ----- sv/tmroc_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the trimmed mean report-on-change unit
// no dependencies

package tmroc_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int TIME_W     = 32;
    localparam int THR_W      = 24;
    localparam int INTV_W     = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic signed [SAMPLE_W-1:0] NO_READING = -24'sd100000;
    localparam int MIN_VALID  = 5;
    localparam int TRIM_COUNT = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_MODE     = 3'd4;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]          now_seconds;
    } t_in_item;

    typedef struct packed {
        logic                       accepted;
        logic                       report;
        logic signed [SAMPLE_W-1:0] report_value;
    } t_out_item;

endpackage

// ----- sv/tmroc_ram.sv -----
`timescale 1ns / 1ps
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module tmroc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/tmroc_div.sv -----
`timescale 1ns / 1ps
// unsigned restoring divider, one quotient bit per cycle
// no dependencies

module tmroc_div #(
    parameter int NUM_W = 29,
    parameter int DEN_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign fits  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], fits};
            if (fits) begin
                r_rem <= DEN_W'(trial - {1'b0, r_den});
            end else begin
                r_rem <= trial[DEN_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ----- sv/trimmed_mean_report_on_change_unit.sv -----
`timescale 1ns / 1ps
// top level of the trimmed mean report-on-change unit
// depends on tmroc_pkg, tmroc_ram and tmroc_div

// Takes one sensor sample with a seconds timestamp per transfer and returns one
// result per sample. Samples that are the no-reading code or lie outside
// [min_value, max_value] are dropped with accepted 0; others are stored in a
// HISTORY_DEPTH-entry ring held in a ram. In average mode the history is
// scanned through the single ram read port, entries equal to min_value are
// skipped, the two largest and two smallest remaining valid entries are trimmed
// and the rest divided by a one-bit-per-cycle divider; fewer than five such
// entries gives no report. A report is made when the value is in range, the time
// is later than the last report, and the change reaches change_threshold or
// max_interval has run out. A dropped sample goes straight to the output stage,
// single-sample mode passes two compare states, and average mode first runs the
// scan, two trim states and the SUM_W = 25 + clog2(HISTORY_DEPTH) bit divider. The
// next sample is taken while the previous result waits in the output register.

module trimmed_mean_report_on_change_unit import tmroc_pkg::*; #(
    parameter int HISTORY_DEPTH = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW    = $clog2(HISTORY_DEPTH);
    localparam int CW    = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W = SAMPLE_W + $clog2(HISTORY_DEPTH) + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_TRIM1 = 4'd2;
    localparam logic [3:0] S_TRIM2 = 4'd3;
    localparam logic [3:0] S_DIVS  = 4'd4;
    localparam logic [3:0] S_DIVW  = 4'd5;
    localparam logic [3:0] S_CMP1  = 4'd6;
    localparam logic [3:0] S_CMP2  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    // control state
    logic [3:0]                 r_state;
    logic [3:0]                 n_state;
    logic [AW-1:0]              r_wi;
    logic [AW-1:0]              n_wi;
    logic [HISTORY_DEPTH-1:0]   r_hvalid;
    logic [CW-1:0]              r_idx;
    logic                       r_dv;
    logic                       r_out_valid;

    // configuration
    logic signed [SAMPLE_W-1:0] r_min;
    logic signed [SAMPLE_W-1:0] r_max;
    logic [THR_W-1:0]           r_thr;
    logic [INTV_W-1:0]          r_intv;
    logic                       r_avg;

    // report history
    logic signed [SAMPLE_W-1:0] r_last_rep;
    logic [TIME_W-1:0]          r_last_time;

    // datapath
    logic [AW-1:0]              r_didx;
    logic [TIME_W-1:0]          r_now;
    logic                       r_late;
    logic signed [SAMPLE_W-1:0] r_val;
    logic signed [SAMPLE_W-1:0] r_hi1;
    logic signed [SAMPLE_W-1:0] r_hi2;
    logic signed [SAMPLE_W-1:0] r_lo1;
    logic signed [SAMPLE_W-1:0] r_lo2;
    logic signed [SUM_W-1:0]    r_sum;
    logic [CW-1:0]              r_cnt;
    logic                       r_neg;
    logic                       r_inrng;
    logic signed [SAMPLE_W:0]   r_diff;
    t_out_item                  r_res;
    t_out_item                  r_out;

    logic                       in_xfer;
    logic                       out_xfer;
    logic                       in_ok;
    logic signed [SAMPLE_W-1:0] s;
    logic                       ram_re;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic signed [SAMPLE_W-1:0] v;
    logic                       take;
    logic signed [SUM_W-1:0]    ext_v;
    logic signed [SUM_W-1:0]    ext_hi;
    logic signed [SUM_W-1:0]    ext_lo;
    logic [SUM_W-1:0]           sum_mag;
    logic                       div_done;
    logic [SUM_W-1:0]           div_quo;
    logic [SAMPLE_W-1:0]        quo_low;
    logic [SAMPLE_W:0]          abs_diff;
    logic [TIME_W:0]            deadline;
    logic                       changed;
    logic                       expired;
    logic                       load_out;

    assign s        = i_in_item.sample;
    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = r_out_valid && !i_out_stall;
    assign in_ok    = (s != NO_READING) && (s >= r_min) && (s <= r_max);
    assign n_wi     = (r_wi == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wi + 1'b1;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign ram_re = (r_state == S_SCAN) && (r_idx != CW'(HISTORY_DEPTH));
    assign v      = $signed(ram_rdata);
    assign take   = r_dv && r_hvalid[r_didx] && (v != r_min);
    assign ext_v  = $signed({{(SUM_W-SAMPLE_W){v[SAMPLE_W-1]}}, v});
    assign ext_hi = $signed({{(SUM_W-SAMPLE_W){r_hi1[SAMPLE_W-1]}}, r_hi1})
                  + $signed({{(SUM_W-SAMPLE_W){r_hi2[SAMPLE_W-1]}}, r_hi2});
    assign ext_lo = $signed({{(SUM_W-SAMPLE_W){r_lo1[SAMPLE_W-1]}}, r_lo1})
                  + $signed({{(SUM_W-SAMPLE_W){r_lo2[SAMPLE_W-1]}}, r_lo2});
    assign sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign quo_low = div_quo[SAMPLE_W-1:0];

    assign abs_diff = r_diff[SAMPLE_W] ? (SAMPLE_W+1)'(-r_diff) : (SAMPLE_W+1)'(r_diff);
    assign deadline = {1'b0, r_last_time} + {{(TIME_W+1-INTV_W){1'b0}}, r_intv};
    assign changed  = (abs_diff >= {{(SAMPLE_W+1-THR_W){1'b0}}, r_thr});
    assign expired  = ({1'b0, r_now} > deadline);
    assign load_out = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    tmroc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (in_xfer && in_ok),
        .i_waddr (n_wi),
        .i_wdata (s),
        .i_re    (ram_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    tmroc_div #(
        .NUM_W (SUM_W),
        .DEN_W (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIVS),
        .i_num   (sum_mag),
        .i_den   (r_cnt - CW'(TRIM_COUNT)),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (!in_ok) begin
                        n_state = S_FIN;
                    end else if (r_avg) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_CMP1;
                    end
                end
            end
            S_SCAN: begin
                if (r_idx == CW'(HISTORY_DEPTH) && !r_dv) begin
                    n_state = S_TRIM1;
                end
            end
            S_TRIM1: begin
                n_state = (r_cnt < CW'(MIN_VALID)) ? S_FIN : S_TRIM2;
            end
            S_TRIM2: n_state = S_DIVS;
            S_DIVS:  n_state = S_DIVW;
            S_DIVW: begin
                if (div_done) begin
                    n_state = S_CMP1;
                end
            end
            S_CMP1:  n_state = S_CMP2;
            S_CMP2:  n_state = S_FIN;
            S_FIN: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wi        <= '0;
            r_hvalid    <= '0;
            r_idx       <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_min       <= '0;
            r_max       <= 24'sd10000;
            r_thr       <= 24'd100;
            r_intv      <= 17'd900;
            r_avg       <= 1'b0;
            r_last_rep  <= '0;
            r_last_time <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MIN_VALUE:        r_min  <= $signed(i_cfg_data[SAMPLE_W-1:0]);
                    CFG_MAX_VALUE:        r_max  <= $signed(i_cfg_data[SAMPLE_W-1:0]);
                    CFG_CHANGE_THRESHOLD: r_thr  <= i_cfg_data[THR_W-1:0];
                    CFG_MAX_INTERVAL:     r_intv <= i_cfg_data[INTV_W-1:0];
                    CFG_AVERAGE_MODE:     r_avg  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (in_xfer && in_ok) begin
                r_wi           <= n_wi;
                r_hvalid[n_wi] <= 1'b1;
                r_idx          <= '0;
                r_dv           <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_dv <= ram_re;
                if (ram_re) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (r_state == S_CMP2 && r_inrng && (changed || expired)) begin
                r_last_rep  <= r_val;
                r_last_time <= r_now;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_now          <= i_in_item.now_seconds;
            r_late         <= (i_in_item.now_seconds > r_last_time);
            r_val          <= s;
            r_sum          <= '0;
            r_cnt          <= '0;
            r_res.accepted <= in_ok;
            r_res.report   <= 1'b0;
            r_res.report_value <= '0;
        end
        if (ram_re) begin
            r_didx <= r_idx[AW-1:0];
        end
        // running top two and bottom two, ties kept as separate entries
        if (r_state == S_SCAN && take) begin
            r_sum <= r_sum + ext_v;
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == '0) begin
                r_hi1 <= v;
                r_lo1 <= v;
            end else if (r_cnt == CW'(1)) begin
                if (v > r_hi1) begin
                    r_hi2 <= r_hi1;
                    r_hi1 <= v;
                end else begin
                    r_hi2 <= v;
                end
                if (v < r_lo1) begin
                    r_lo2 <= r_lo1;
                    r_lo1 <= v;
                end else begin
                    r_lo2 <= v;
                end
            end else begin
                if (v > r_hi1) begin
                    r_hi2 <= r_hi1;
                    r_hi1 <= v;
                end else if (v > r_hi2) begin
                    r_hi2 <= v;
                end
                if (v < r_lo1) begin
                    r_lo2 <= r_lo1;
                    r_lo1 <= v;
                end else if (v < r_lo2) begin
                    r_lo2 <= v;
                end
            end
        end
        if (r_state == S_TRIM1) begin
            r_sum <= r_sum - ext_hi;
        end
        if (r_state == S_TRIM2) begin
            r_sum <= r_sum - ext_lo;
        end
        if (r_state == S_DIVS) begin
            r_neg <= r_sum[SUM_W-1];
        end
        if (r_state == S_DIVW && div_done) begin
            r_val <= r_neg ? $signed(SAMPLE_W'(-quo_low)) : $signed(quo_low);
        end
        if (r_state == S_CMP1) begin
            r_inrng <= (r_val >= r_min) && (r_val <= r_max) && r_late;
            r_diff  <= $signed({r_val[SAMPLE_W-1], r_val})
                     - $signed({r_last_rep[SAMPLE_W-1], r_last_rep});
        end
        if (r_state == S_CMP2 && r_inrng && (changed || expired)) begin
            r_res.report       <= 1'b1;
            r_res.report_value <= r_val;
        end
        if (load_out) begin
            r_out <= r_res;
        end
    end

    // a report only comes with a stored sample
    a_report_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_item.report || o_out_item.accepted))
        else $error("report without accepted sample");

    // the divider finishes only while the sequencer waits for it
    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIVW))
        else $error("divider result outside wait state");

    // the history scan never runs past the ring
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= CW'(HISTORY_DEPTH))
        else $error("history scan index out of range");

    // at most one history entry becomes valid per transfer
    a_valid_growth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ($countones(r_hvalid) <= $countones($past(r_hvalid)) + 1))
        else $error("history valid bits grew too fast");

endmodule
